// File: hw/rtl/tvr_pkg.sv
// shared types, constants and the arctangent table of the triangle vertex rotator
`timescale 1ns / 1ps
package tvr_pkg;

    // field widths
    localparam int IDX_W   = 16;
    localparam int RAD_W   = 10;
    localparam int STEP_W  = 17;
    localparam int CNT_W   = 16;
    localparam int CEN_W   = 11;
    localparam int COORD_W = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COUNT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = CFG_IDX_W'(4);

    localparam logic [RAD_W-1:0]  RADIUS_RST     = RAD_W'(100);
    localparam logic [STEP_W-1:0] ANGLE_STEP_RST = STEP_W'(2560);
    localparam logic [CNT_W-1:0]  ROT_COUNT_RST  = CNT_W'(36);
    localparam logic [CEN_W-1:0]  CENTER_X_RST   = CEN_W'(300);
    localparam logic [CEN_W-1:0]  CENTER_Y_RST   = CEN_W'(150);

    // angles in 1/256 degree
    localparam int ANG_W         = 17;
    localparam int FULL_TURN     = 92160;
    localparam int HALF_TURN     = 46080;
    localparam int QUARTER_TURN  = 23040;
    localparam int THREE_QUARTER = 69120;
    localparam int THIRD_TURN    = 30720;
    localparam int ZSH           = 8;

    // modulo a full turn: full turn = 45 * 2^11
    localparam int PROD_W   = IDX_W + STEP_W;
    localparam int LOW_W    = 11;
    localparam int HI_W     = PROD_W - LOW_W;
    localparam int MOD_HI   = FULL_TURN / (2 ** LOW_W);
    localparam int RECIP_SH = 28;
    localparam int RECIP    = (2 ** RECIP_SH) / MOD_HI;
    localparam int RECIP_W  = 23;
    localparam int RP_W     = HI_W + RECIP_W;
    localparam int Q_W      = RP_W - RECIP_SH;
    localparam int REM_W    = 7;

    // cordic
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int Z_W           = 25;
    localparam int XY_W          = 33;
    localparam int GAIN_Q30      = 652032874;
    localparam int Q15_SH        = 15;
    localparam int TRIG_W        = 16;
    localparam int TQ_W          = XY_W - Q15_SH;

    // coordinate arithmetic
    localparam int MUL_W = RAD_W + 1 + TRIG_W;
    localparam int V_W   = MUL_W + 2;
    localparam int CR_W  = V_W - Q15_SH;

    localparam int VTX_N       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef logic signed [Z_W-1:0] z_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef enum logic [1:0] {
        VTX_FIRST  = 2'd0,
        VTX_SECOND = 2'd1,
        VTX_THIRD  = 2'd2
    } vtx_t;

    typedef struct packed {
        logic [RAD_W-1:0]  radius;
        logic [STEP_W-1:0] angle_step;
        logic [CNT_W-1:0]  rotation_count;
        logic [CEN_W-1:0]  center_x;
        logic [CEN_W-1:0]  center_y;
    } cfg_t;

    // one classified item: folded cordic angle and negate flag per vertex
    typedef struct packed {
        logic              oor;
        logic [VTX_N-1:0]  neg;
        z_t [VTX_N-1:0]    z;
    } entry_t;

    // arctangent of 2^-i in 2^-16 degree, rounded to nearest
    function automatic z_t atan_lut(input logic [4:0] i);
        case (i)
            5'd0:    return Z_W'(2949120);
            5'd1:    return Z_W'(1740967);
            5'd2:    return Z_W'(919879);
            5'd3:    return Z_W'(466945);
            5'd4:    return Z_W'(234379);
            5'd5:    return Z_W'(117304);
            5'd6:    return Z_W'(58666);
            5'd7:    return Z_W'(29335);
            5'd8:    return Z_W'(14668);
            5'd9:    return Z_W'(7334);
            5'd10:   return Z_W'(3667);
            5'd11:   return Z_W'(1833);
            5'd12:   return Z_W'(917);
            5'd13:   return Z_W'(458);
            5'd14:   return Z_W'(229);
            5'd15:   return Z_W'(115);
            5'd16:   return Z_W'(57);
            5'd17:   return Z_W'(29);
            5'd18:   return Z_W'(14);
            5'd19:   return Z_W'(7);
            5'd20:   return Z_W'(4);
            5'd21:   return Z_W'(2);
            5'd22:   return Z_W'(1);
            default: return '0;
        endcase
    endfunction

endpackage

// File: hw/rtl/tvr_in_if.sv
// index channel carrying one rotation index per transaction
`timescale 1ns / 1ps
interface tvr_in_if;
    import tvr_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] rotation_index;

    modport source (output valid, output rotation_index, input ready);
    modport sink (input valid, input rotation_index, output ready);
endinterface

// File: hw/rtl/tvr_out_if.sv
// vertex channel carrying three rounded vertices and the range flag per transaction
`timescale 1ns / 1ps
interface tvr_out_if;
    import tvr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    coord_t third_x;
    coord_t third_y;
    logic   out_of_range;

    modport source (
        output valid, output first_x, output first_y, output second_x,
        output second_y, output third_x, output third_y, output out_of_range,
        input ready
    );
    modport sink (
        input valid, input first_x, input first_y, input second_x,
        input second_y, input third_x, input third_y, input out_of_range,
        output ready
    );
endinterface

// File: hw/rtl/triangle_vertex_rotator.sv
// triangle vertex rotator top level: configuration registers, front, queue and back
// index_chan takes one rotation index per transaction; vertex_chan returns, per
// index, the three rounded vertices of the rotated triangle and the range flag
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); registers
// are radius, angle_step, rotation_count, center_x, center_y at index 0 to 4,
// and an unknown index is dropped
// the front computes index * step modulo a full turn (multiplier, reciprocal
// divide by 45, remainder fix) in three stages, then folds each vertex angle
// a four-entry queue parts the front from the back
// the back shares one cordic pipeline of CORDIC_STAGES stages across the three
// vertices, one vertex a cycle while the output is not stalled and the queue
// holds an item; the next item's vertices follow without waiting for the last
// item to leave the pipeline
// reset returns the registers to their defaults and empties every stage
// when the receiver stalls, the back freezes with its result held; the queue
// keeps filling, and index_chan.ready drops once the queue is full and the
// front's last stage holds an item
`timescale 1ns / 1ps
module triangle_vertex_rotator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tvr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvr_pkg::CFG_DATA_W-1:0]     cfg_data,
    tvr_in_if.sink                             index_chan,
    tvr_out_if.source                          vertex_chan
);
    import tvr_pkg::*;

    cfg_t   cfg_reg;
    logic   push;
    entry_t push_data;
    logic   full;
    logic   pop;
    entry_t head;
    logic   empty;

    // register writes, to be done only while the block is idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius         <= RADIUS_RST;
            cfg_reg.angle_step     <= ANGLE_STEP_RST;
            cfg_reg.rotation_count <= ROT_COUNT_RST;
            cfg_reg.center_x       <= CENTER_X_RST;
            cfg_reg.center_y       <= CENTER_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:     cfg_reg.radius         <= cfg_data[RAD_W-1:0];
                REG_ANGLE_STEP: cfg_reg.angle_step     <= cfg_data[STEP_W-1:0];
                REG_ROT_COUNT:  cfg_reg.rotation_count <= cfg_data[CNT_W-1:0];
                REG_CENTER_X:   cfg_reg.center_x       <= cfg_data[CEN_W-1:0];
                REG_CENTER_Y:   cfg_reg.center_y       <= cfg_data[CEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // angle reduction and fold
    tvr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .index_chan (index_chan),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    // decouples the front from the back
    tvr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // cordic, scaling, rounding and result register
    tvr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .vertex_chan (vertex_chan)
    );

endmodule

// File: hw/rtl/tvr_front.sv
// front end: base angle, modulo reduction and per-vertex quadrant fold
`timescale 1ns / 1ps
module tvr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  tvr_pkg::cfg_t   cfg,
    tvr_in_if.sink          index_chan,
    output logic            push,
    output tvr_pkg::entry_t push_data,
    input  logic            full
);
    import tvr_pkg::*;

    logic              adv;
    logic              fire;
    logic              v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              oor1_reg, oor2_reg, oor3_reg;
    logic [HI_W-1:0]   hi2_reg;
    logic [LOW_W-1:0]  low2_reg;
    logic [RP_W-1:0]   recip_prod;
    logic [Q_W-1:0]    q_reg;
    logic [HI_W-1:0]   rem_full;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  rem_red;
    logic [ANG_W-1:0]  base_reg;
    logic [ANG_W-1:0]  base_next;

    logic [ANG_W:0]         turn_sum [VTX_N];
    logic [ANG_W-1:0]       turn_ang [VTX_N];
    logic signed [ANG_W:0]  fold_ang [VTX_N];

    assign adv              = !v3_reg || !full;
    assign index_chan.ready = adv;
    assign fire             = index_chan.valid && adv;
    assign push             = v3_reg && !full;

    assign prod_next  = PROD_W'(index_chan.rotation_index) * PROD_W'(cfg.angle_step);
    assign recip_prod = RP_W'(prod_reg[PROD_W-1:LOW_W]) * RP_W'(RECIP);
    assign rem_full   = hi2_reg - HI_W'(q_reg) * HI_W'(MOD_HI);
    assign rem        = rem_full[REM_W-1:0];
    assign rem_red    = (rem >= REM_W'(MOD_HI)) ? rem - REM_W'(MOD_HI) : rem;
    assign base_next  = {rem_red[ANG_W-LOW_W-1:0], low2_reg};

    // three vertices a third of a turn apart, folded into [-90, 90] degrees
    always_comb
    begin
        push_data.oor = oor3_reg;
        for (int k = 0; k < VTX_N; k++)
        begin
            turn_sum[k] = {1'b0, base_reg} + (ANG_W+1)'(k * THIRD_TURN);
            if (turn_sum[k] >= (ANG_W+1)'(FULL_TURN))
            begin
                turn_ang[k] = ANG_W'(turn_sum[k] - (ANG_W+1)'(FULL_TURN));
            end
            else
            begin
                turn_ang[k] = turn_sum[k][ANG_W-1:0];
            end
            if (turn_ang[k] > ANG_W'(THREE_QUARTER))
            begin
                fold_ang[k]      = $signed({1'b0, turn_ang[k]}) - (ANG_W+1)'(FULL_TURN);
                push_data.neg[k] = 1'b0;
            end
            else if (turn_ang[k] > ANG_W'(QUARTER_TURN))
            begin
                fold_ang[k]      = $signed({1'b0, turn_ang[k]}) - (ANG_W+1)'(HALF_TURN);
                push_data.neg[k] = 1'b1;
            end
            else
            begin
                fold_ang[k]      = $signed({1'b0, turn_ang[k]});
                push_data.neg[k] = 1'b0;
            end
            push_data.z[k] = {fold_ang[k][Z_W-ZSH-1:0], {ZSH{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            oor1_reg <= (index_chan.rotation_index >= cfg.rotation_count);
            hi2_reg  <= prod_reg[PROD_W-1:LOW_W];
            low2_reg <= prod_reg[LOW_W-1:0];
            q_reg    <= recip_prod[RP_W-1:RECIP_SH];
            oor2_reg <= oor1_reg;
            base_reg <= base_next;
            oor3_reg <= oor2_reg;
        end
    end

endmodule

// File: hw/rtl/tvr_queue.sv
// short queue of classified items between front and back
`timescale 1ns / 1ps
module tvr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tvr_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output tvr_pkg::entry_t head,
    output logic            empty
);
    import tvr_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/tvr_back.sv
// back end: shared pipelined cordic, one vertex a cycle unless stalled, then scaling and assembly
`timescale 1ns / 1ps
module tvr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tvr_pkg::cfg_t   cfg,
    input  tvr_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    tvr_out_if.source       vertex_chan
);
    import tvr_pkg::*;

    typedef logic signed [XY_W-1:0]  xy_t;
    typedef logic signed [MUL_W-1:0] mul_t;
    typedef logic signed [V_W-1:0]   v_t;

    typedef struct packed {
        vtx_t vk;
        logic neg;
        logic oor;
        xy_t  x;
        xy_t  y;
        z_t   z;
    } cstage_t;

    typedef struct packed {
        vtx_t vk;
        logic oor;
    } meta_t;

    localparam logic signed [TQ_W-1:0] TQ_HI = TQ_W'(32767);
    localparam logic signed [TQ_W-1:0] TQ_LO = TQ_W'(-32768);
    localparam logic signed [CR_W-1:0] CR_HI = CR_W'(2047);
    localparam logic signed [CR_W-1:0] CR_LO = CR_W'(-2048);

    // round to q1.15 half up, apply the half-turn fold, saturate
    function automatic trig_t to_q15(input xy_t v, input logic neg);
        xy_t                   s;
        logic signed [TQ_W-1:0] t;
        s = v + XY_W'(2 ** (Q15_SH - 1));
        t = TQ_W'(s >>> Q15_SH);
        if (neg)
        begin
            t = -t;
        end
        if (t > TQ_HI)
        begin
            t = TQ_HI;
        end
        else if (t < TQ_LO)
        begin
            t = TQ_LO;
        end
        return t[TRIG_W-1:0];
    endfunction

    // divide by 2^15 rounding half away from zero, saturate to the pixel range
    function automatic coord_t to_coord(input v_t v);
        v_t                     s;
        logic signed [CR_W-1:0] r;
        s = v + $signed({{(V_W-Q15_SH){1'b0}}, ~v[V_W-1], {(Q15_SH-1){v[V_W-1]}}});
        r = CR_W'(s >>> Q15_SH);
        if (r > CR_HI)
        begin
            r = CR_HI;
        end
        else if (r < CR_LO)
        begin
            r = CR_LO;
        end
        return r[COORD_W-1:0];
    endfunction

    logic                    adv;
    logic                    issue;
    vtx_t                    vk_reg;
    cstage_t                 st_reg  [CORDIC_STAGES+1];
    cstage_t                 st_next [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]  sv_reg;

    logic [2:0] pv_reg;
    meta_t      m0_reg, m1_reg, m2_reg;
    trig_t      c0_reg, s0_reg;
    mul_t       px_reg, py_reg;
    v_t         vx_reg, vy_reg;
    coord_t     cx, cy;

    coord_t v0x_reg, v0y_reg, v1x_reg, v1y_reg;
    coord_t fx_reg, fy_reg, sx_reg, sy_reg, tx_reg, ty_reg;
    logic   oor_reg;
    logic   out_valid_reg;

    // the whole back end freezes while a finished result waits unread
    assign adv   = !out_valid_reg || vertex_chan.ready;
    assign issue = adv && !empty;
    assign pop   = issue && (vk_reg == VTX_THIRD);

    always_comb
    begin
        st_next[0].vk  = vk_reg;
        st_next[0].neg = head.neg[vk_reg];
        st_next[0].oor = head.oor;
        st_next[0].x   = XY_W'(GAIN_Q30);
        st_next[0].y   = '0;
        st_next[0].z   = head.z[vk_reg];
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        xy_t  xi, yi, dx, dy;
        z_t   zi, ang;
        logic dn;

        assign xi  = st_reg[i].x;
        assign yi  = st_reg[i].y;
        assign zi  = st_reg[i].z;
        assign dx  = yi >>> i;
        assign dy  = xi >>> i;
        assign ang = atan_lut(5'(i));
        assign dn  = zi[Z_W-1];

        always_comb
        begin
            st_next[i+1]     = st_reg[i];
            st_next[i+1].x   = dn ? xi + dx : xi - dx;
            st_next[i+1].y   = dn ? yi - dy : yi + dy;
            st_next[i+1].z   = dn ? zi + ang : zi - ang;
        end
    end

    assign cx = to_coord(vx_reg);
    assign cy = to_coord(vy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vk_reg        <= VTX_FIRST;
            sv_reg        <= '0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                vk_reg <= (vk_reg == VTX_THIRD) ? VTX_FIRST : vtx_t'(vk_reg + 2'd1);
            end
            if (adv)
            begin
                sv_reg <= {sv_reg[CORDIC_STAGES-1:0], !empty};
                pv_reg <= {pv_reg[1:0], sv_reg[CORDIC_STAGES]};
            end
            if (adv && pv_reg[2] && (m2_reg.vk == VTX_THIRD))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (vertex_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= CORDIC_STAGES; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            c0_reg    <= to_q15(st_reg[CORDIC_STAGES].x, st_reg[CORDIC_STAGES].neg);
            s0_reg    <= to_q15(st_reg[CORDIC_STAGES].y, st_reg[CORDIC_STAGES].neg);
            m0_reg.vk  <= st_reg[CORDIC_STAGES].vk;
            m0_reg.oor <= st_reg[CORDIC_STAGES].oor;
            px_reg    <= $signed({1'b0, cfg.radius}) * c0_reg;
            py_reg    <= $signed({1'b0, cfg.radius}) * s0_reg;
            m1_reg    <= m0_reg;
            vx_reg    <= $signed({{(V_W-CEN_W-Q15_SH){1'b0}}, cfg.center_x, {Q15_SH{1'b0}}})
                         + V_W'(px_reg);
            vy_reg    <= $signed({{(V_W-CEN_W-Q15_SH){1'b0}}, cfg.center_y, {Q15_SH{1'b0}}})
                         + V_W'(py_reg);
            m2_reg    <= m1_reg;
            if (pv_reg[2])
            begin
                case (m2_reg.vk)
                    VTX_FIRST:
                    begin
                        v0x_reg <= cx;
                        v0y_reg <= cy;
                    end
                    VTX_SECOND:
                    begin
                        v1x_reg <= cx;
                        v1y_reg <= cy;
                    end
                    VTX_THIRD:
                    begin
                        fx_reg  <= v0x_reg;
                        fy_reg  <= v0y_reg;
                        sx_reg  <= v1x_reg;
                        sy_reg  <= v1y_reg;
                        tx_reg  <= cx;
                        ty_reg  <= cy;
                        oor_reg <= m2_reg.oor;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign vertex_chan.valid        = out_valid_reg;
    assign vertex_chan.first_x      = fx_reg;
    assign vertex_chan.first_y      = fy_reg;
    assign vertex_chan.second_x     = sx_reg;
    assign vertex_chan.second_y     = sy_reg;
    assign vertex_chan.third_x      = tx_reg;
    assign vertex_chan.third_y      = ty_reg;
    assign vertex_chan.out_of_range = oor_reg;

endmodule

// File: tb/triangle_vertex_rotator_test.sv
// self-checking testbench for the triangle vertex rotator
`timescale 1ns / 1ps
module triangle_vertex_rotator_test;
    import tvr_pkg::*;

    // angles in 1/256 degree, as the block keeps them
    localparam longint ANG_TURN          = 92160;
    localparam longint ANG_HALF          = 46080;
    localparam longint ANG_QUARTER       = 23040;
    localparam longint ANG_THREE_QUARTER = 69120;
    localparam longint ANG_THIRD         = 30720;

    // cordic constants: converged gain in Q30, arctangent of 2^-i in 2^-16 degree
    localparam int     ATAN_LEN   = 24;
    localparam longint KGAIN_Q30  = 652032874;
    localparam longint ATAN_DEG16 [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // settle time after the drain, in which a stray transaction could still show up
    localparam int SETTLE_CYCLES = CORDIC_STAGES + 24;

    // one vertex transaction as the checker sees it
    typedef struct packed {
        coord_t first_x;
        coord_t first_y;
        coord_t second_x;
        coord_t second_y;
        coord_t third_x;
        coord_t third_y;
        logic   out_of_range;
    } vertex_set_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tvr_in_if  index_chan ();
    tvr_out_if vertex_chan ();

    triangle_vertex_rotator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .index_chan  (index_chan),
        .vertex_chan (vertex_chan)
    );

    // predictor's own copy of the configuration registers
    logic [RAD_W-1:0]  cur_radius;
    logic [STEP_W-1:0] cur_step;
    logic [CNT_W-1:0]  cur_count;
    logic [CEN_W-1:0]  cur_cx;
    logic [CEN_W-1:0]  cur_cy;

    vertex_set_t pending_vertices [$];
    reg_write_t  reg_writes [$];

    // idling knobs of the sender and the receiver, and the mismatch count
    int send_gap_max = 13;
    int stall_max    = 13;
    int hold_request = 0;
    int mismatches   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // rotation-mode cordic on an angle in 0..ANG_TURN-1, giving Q1.15 cos and sin
    function automatic void cordic_trig(input longint ang, output longint cos_q,
                                        output longint sin_q);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        int     i;
        a    = ang;
        flip = 1'b0;
        // fold into [-90, 90] degrees; a half-turn fold negates both results
        if (a > ANG_THREE_QUARTER)
            a = a - ANG_TURN;
        else if (a > ANG_QUARTER)
        begin
            a    = a - ANG_HALF;
            flip = 1'b1;
        end
        x = KGAIN_Q30;
        y = 0;
        z = a * 256;
        for (i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG16[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG16[i];
            end
        end
        // round to Q1.15
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        // cosine or sine of exactly one saturates
        cos_q = (x > 32767) ? 32767 : ((x < -32768) ? -32768 : x);
        sin_q = (y > 32767) ? 32767 : ((y < -32768) ? -32768 : y);
    endfunction

    // centre plus radius times trig, rounded half away from zero, saturated to 12 bits
    function automatic coord_t to_pixel(input longint centre, input longint trig);
        longint v;
        longint r;
        v = centre * 32768 + longint'(cur_radius) * trig;
        if (v >= 0)
            r = (v + 16384) / 32768;
        else
            r = -((-v + 16384) / 32768);
        if (r > 2047)
            r = 2047;
        if (r < -2048)
            r = -2048;
        return coord_t'(r);
    endfunction

    function automatic vertex_set_t predict_vertices(input logic [IDX_W-1:0] idx);
        vertex_set_t v;
        longint      base;
        longint      ang;
        longint      c;
        longint      s;
        coord_t      px [3];
        coord_t      py [3];
        int          k;
        // product reduced modulo a full turn, so steps beyond 360 degrees wrap
        base = (longint'(idx) * longint'(cur_step)) % ANG_TURN;
        for (k = 0; k < 3; k++)
        begin
            ang = (base + k * ANG_THIRD) % ANG_TURN;
            cordic_trig(ang, c, s);
            px[k] = to_pixel(longint'(cur_cx), c);
            py[k] = to_pixel(longint'(cur_cy), s);
        end
        v.first_x      = px[0];
        v.first_y      = py[0];
        v.second_x     = px[1];
        v.second_y     = py[1];
        v.third_x      = px[2];
        v.third_y      = py[2];
        // vertices are still produced when the index is past the count
        v.out_of_range = (idx >= cur_count);
        return v;
    endfunction

    function automatic void reset_registers();
        cur_radius = RADIUS_RST;
        cur_step   = ANGLE_STEP_RST;
        cur_count  = ROT_COUNT_RST;
        cur_cx     = CENTER_X_RST;
        cur_cy     = CENTER_Y_RST;
    endfunction

    // upper data bits beyond a register's width are dropped; spare indexes do nothing
    function automatic void note_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_RADIUS:     cur_radius = data[RAD_W-1:0];
            REG_ANGLE_STEP: cur_step   = data[STEP_W-1:0];
            REG_ROT_COUNT:  cur_count  = data[CNT_W-1:0];
            REG_CENTER_X:   cur_cx     = data[CEN_W-1:0];
            REG_CENTER_Y:   cur_cy     = data[CEN_W-1:0];
            default:        ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------

    function automatic string describe_vertices(input vertex_set_t v);
        return $sformatf("(%0d,%0d) (%0d,%0d) (%0d,%0d) oor=%0b", v.first_x, v.first_y,
                         v.second_x, v.second_y, v.third_x, v.third_y, v.out_of_range);
    endfunction

    function automatic void log_mismatch(input string what, input string want,
                                         input string got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %s, got %s", $time, what, want, got);
    endfunction

    // every vertex transaction is compared against the oldest prediction
    initial
    begin : vertex_monitor
        vertex_set_t got;
        vertex_set_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && vertex_chan.valid === 1'b1 && vertex_chan.ready === 1'b1)
            begin
                got.first_x      = vertex_chan.first_x;
                got.first_y      = vertex_chan.first_y;
                got.second_x     = vertex_chan.second_x;
                got.second_y     = vertex_chan.second_y;
                got.third_x      = vertex_chan.third_x;
                got.third_y      = vertex_chan.third_y;
                got.out_of_range = vertex_chan.out_of_range;
                if (pending_vertices.size() == 0)
                    log_mismatch("vertex transaction with nothing pending", "none",
                                 describe_vertices(got));
                else
                begin
                    want = pending_vertices.pop_front();
                    if (got !== want)
                        log_mismatch("vertex mismatch", describe_vertices(want),
                                     describe_vertices(got));
                end
            end
        end
    end

    // receiver: random stall before each transaction, or one long hold-off on request
    initial
    begin : vertex_sink
        int stall;
        vertex_chan.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else
                stall = $urandom_range(stall_max, 0);
            if (stall > 0)
            begin
                vertex_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            vertex_chan.ready <= 1'b1;
            do
                @(posedge clk);
            while (vertex_chan.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers, entered and left on a rising edge
    // ------------------------------------------------------------------

    // offers one index after a random gap; valid stays high into a back-to-back item
    task automatic send_index(input logic [IDX_W-1:0] idx);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            index_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        index_chan.valid          <= 1'b1;
        index_chan.rotation_index <= idx;
        do
            @(posedge clk);
        while (index_chan.ready !== 1'b1);
        pending_vertices.push_back(predict_vertices(idx));
    endtask

    // stop offering and wait until every predicted transaction has come back
    task automatic wait_for_vertices();
        index_chan.valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic apply_reg_writes();
        reg_write_t w;
        while (reg_writes.size() > 0)
        begin
            w = reg_writes.pop_front();
            cfg_we    <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            @(posedge clk);
            note_register(w.index, w.data);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // registers only change with the block drained
    task automatic set_all_regs(input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] s,
                                input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] x,
                                input logic [CFG_DATA_W-1:0] y);
        wait_for_vertices();
        reg_writes.push_back('{REG_RADIUS, r});
        reg_writes.push_back('{REG_ANGLE_STEP, s});
        reg_writes.push_back('{REG_ROT_COUNT, c});
        reg_writes.push_back('{REG_CENTER_X, x});
        reg_writes.push_back('{REG_CENTER_Y, y});
        apply_reg_writes();
    endtask

    // mostly indexes inside the sequence, the rest on the boundary or anywhere
    function automatic logic [IDX_W-1:0] pick_index();
        if (cur_count != 0 && $urandom_range(3, 0) != 0)
            return IDX_W'($urandom_range(int'(cur_count) - 1, 0));
        case ($urandom_range(3, 0))
            0:       return IDX_W'(cur_count);
            1:       return IDX_W'(cur_count - 1'b1);
            default: return IDX_W'($urandom());
        endcase
    endfunction

    // random register values with junk above each register's width
    task automatic randomise_config();
        logic [CFG_DATA_W-1:0] r;
        logic [CFG_DATA_W-1:0] s;
        logic [CFG_DATA_W-1:0] c;
        logic [CFG_DATA_W-1:0] x;
        logic [CFG_DATA_W-1:0] y;
        r = CFG_DATA_W'($urandom());
        case ($urandom_range(5, 0))
            0:       r[RAD_W-1:0] = '0;
            1:       r[RAD_W-1:0] = '1;
            default: ;
        endcase
        case ($urandom_range(7, 0))
            0:       s = '0;
            1:       s = CFG_DATA_W'(ANG_TURN - 1);
            2:       s = CFG_DATA_W'($urandom());
            default: s = CFG_DATA_W'($urandom_range(int'(ANG_TURN) - 1, 0));
        endcase
        c = CFG_DATA_W'($urandom());
        case ($urandom_range(7, 0))
            0:       c[CNT_W-1:0] = '0;
            1:       c[CNT_W-1:0] = '1;
            2, 3:    c[CNT_W-1:0] = CNT_W'($urandom_range(64, 1));
            default: ;
        endcase
        x = CFG_DATA_W'($urandom());
        y = CFG_DATA_W'($urandom());
        case ($urandom_range(5, 0))
            0:
            begin
                x[CEN_W-1:0] = '0;
                y[CEN_W-1:0] = '1;
            end
            1:
            begin
                x[CEN_W-1:0] = '1;
                y[CEN_W-1:0] = '0;
            end
            default: ;
        endcase
        set_all_regs(r, s, c, x, y);
        // now and then a write to an unused index, which must change nothing
        if ($urandom_range(3, 0) == 0)
        begin
            reg_writes.push_back('{REG_CENTER_Y + CFG_IDX_W'($urandom_range(3, 1)),
                                   CFG_DATA_W'($urandom())});
            apply_reg_writes();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // defaults: 10 degree step, 36 rotations, radius 100 about (300, 150)
    task automatic test_reset_defaults();
        send_index(IDX_W'(0));
        send_index(IDX_W'(9));      // 90 degrees
        send_index(IDX_W'(18));     // 180 degrees, folded and negated
        send_index(IDX_W'(27));     // 270 degrees
        send_index(IDX_W'(35));     // last in range
        send_index(IDX_W'(36));     // first out of range
        send_index('1);
    endtask

    task automatic test_config_extremes();
        // largest radius and centre: x saturates at the top of the range
        set_all_regs(CFG_DATA_W'(1023), CFG_DATA_W'(ANG_TURN - 1), CFG_DATA_W'(65535),
                     CFG_DATA_W'(2047), CFG_DATA_W'(0));
        send_index(IDX_W'(0));
        send_index(IDX_W'(1));
        send_index(IDX_W'(65534));
        send_index('1);
        // zero radius, zero step, zero count: every index out of range
        set_all_regs(CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(0),
                     CFG_DATA_W'(0), CFG_DATA_W'(2047));
        send_index(IDX_W'(0));
        send_index('1);
        // step beyond a full turn wraps
        set_all_regs(CFG_DATA_W'(1023), '1, CFG_DATA_W'(2),
                     CFG_DATA_W'(1024), CFG_DATA_W'(1024));
        send_index(IDX_W'(1));
        send_index(IDX_W'(3));
        // quarter-turn steps about the origin: sine and cosine of exactly one
        set_all_regs(CFG_DATA_W'(1023), CFG_DATA_W'(ANG_QUARTER), CFG_DATA_W'(4),
                     CFG_DATA_W'(0), CFG_DATA_W'(0));
        send_index(IDX_W'(1));
        send_index(IDX_W'(2));
        send_index(IDX_W'(3));
    endtask

    // writes to the unused indexes leave every register as it was
    task automatic test_spare_register();
        int k;
        wait_for_vertices();
        for (k = 1; k <= 3; k++)
            reg_writes.push_back('{REG_CENTER_Y + CFG_IDX_W'(k), '1});
        apply_reg_writes();
        send_index(IDX_W'(0));
        send_index(IDX_W'(3));
    endtask

    task automatic test_random_sweep();
        int phase;
        int n;
        for (phase = 0; phase < 7; phase++)
        begin
            randomise_config();
            // cycle through idling on both sides, on one side only, and stretches with none
            case (phase % 4)
                0:
                begin
                    send_gap_max = 13;
                    stall_max    = 13;
                end
                1:
                begin
                    send_gap_max = 0;
                    stall_max    = 13;
                end
                2:
                begin
                    send_gap_max = 13;
                    stall_max    = 0;
                end
                default:
                begin
                    send_gap_max = 0;
                    stall_max    = 0;
                end
            endcase
            for (n = 0; n < 160; n++)
                send_index(pick_index());
        end
    endtask

    // the receiver holds off long enough for the queue to fill and the index
    // channel to stall, while the sender keeps offering back-to-back items
    task automatic test_back_pressure();
        int n;
        randomise_config();
        send_gap_max = 0;
        stall_max    = 3;
        hold_request = 150;
        for (n = 0; n < 48; n++)
            send_index(pick_index());
        // sender pauses until the backlog has fully drained
        wait_for_vertices();
        send_gap_max = 13;
        stall_max    = 13;
        for (n = 0; n < 12; n++)
            send_index(pick_index());
    endtask

    initial
    begin : run_tests
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= '0;
        cfg_data                  <= '0;
        index_chan.valid          <= 1'b0;
        index_chan.rotation_index <= '0;
        reset_registers();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_spare_register();
        test_random_sweep();
        test_back_pressure();

        // drain, then give any stray transaction time to show up
        wait_for_vertices();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // overall time limit, far beyond the slowest legal run
    initial
    begin : watchdog
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
